/* hw/rtl/ax25t_pkg.sv */
// ----------------------------------------------------------------------------
// ax25t_pkg: shared types and constants for the AX.25 header-to-text block
// Holds the command record passed from the front parser to the text emitter.
// ----------------------------------------------------------------------------
package ax25t_pkg;

    localparam int MAX_LINE  = 190;
    localparam int MAX_DIGIS = 8;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_DEST = 3'd0,
        PH_SRC  = 3'd1,
        PH_DIGI = 3'd2,
        PH_CTRL = 3'd3,
        PH_PID  = 3'd4,
        PH_INFO = 3'd5
    } phase_t;

    // Emitter micro-steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CALL,     // source/digi callsign byte
        ST_SSID,     // "-n" of a byte's ssid
        ST_GT,
        ST_DCALL,    // destination callsign bytes 0..5
        ST_DSSID,
        ST_COMMA,
        ST_STAR,
        ST_HOWN,     // ",OWN-n*" start
        ST_OCALL,
        ST_OSSID,
        ST_OSTAR,
        ST_COLON,
        ST_INFO,
        ST_TILDE,
        ST_CR,
        ST_LF,
        ST_NUL,
        ST_FIN
    } est_t;

    // One command per accepted byte
    typedef struct packed {
        logic [7:0] b;
        logic [2:0] phase;  // phase the byte was processed in
        logic [2:0] pos;    // byte position within field
        logic       hdr_end;
        logic       fend;
        logic [55:0] dest;  // destination snapshot, byte 0 lowest
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

/* hw/rtl/ax25t_front.sv */
// ----------------------------------------------------------------------------
// ax25t_front: frame byte parser
// Tracks the address field structure and queues one command per byte.
// ----------------------------------------------------------------------------
module ax25t_front import ax25t_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [3:0]  digi_reg, digi_next;
    logic [7:0]  dest_reg [7];
    cmd_t        q_mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic        push, pop;
    cmd_t        c;

    assign in_ready  = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH)) ;
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rp_reg];

    // Classify the byte and compute next parse state
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        digi_next  = digi_reg;
        c.b        = in_byte;
        c.phase    = phase_reg;
        c.pos      = pos_reg;
        c.hdr_end  = 1'b0;
        c.fend     = in_end;
        c.dest     = {dest_reg[6], dest_reg[5], dest_reg[4], dest_reg[3],
                      dest_reg[2], dest_reg[1], dest_reg[0]};
        case (phase_reg)
            PH_DEST: begin
                if (pos_reg == 3'd6) begin
                    pos_next = '0; phase_next = PH_SRC;
                end else pos_next = pos_reg + 3'd1;
            end
            PH_SRC: begin
                if (pos_reg != 3'd6) pos_next = pos_reg + 3'd1;
                else begin
                    pos_next = '0;
                    if (in_byte[0]) begin
                        c.hdr_end = 1'b1; phase_next = PH_CTRL;
                    end else phase_next = PH_DIGI;
                end
            end
            PH_DIGI: begin
                if (pos_reg != 3'd6) pos_next = pos_reg + 3'd1;
                else begin
                    pos_next  = '0;
                    digi_next = digi_reg + 4'd1;
                    if (in_byte[0] || (digi_next >= 4'(MAX_DIGIS))) begin
                        c.hdr_end = 1'b1; phase_next = PH_CTRL;
                    end
                end
            end
            PH_CTRL: phase_next = PH_PID;
            PH_PID:  phase_next = PH_INFO;
            default: ;
        endcase
        if (in_end) begin
            phase_next = PH_DEST; pos_next = '0; digi_next = '0;
        end
    end

    // Advance parse state and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DEST;
            pos_reg   <= '0;
            digi_reg  <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            if (push) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                digi_reg  <= digi_next;
                wp_reg    <= wp_reg + QAW'(1);
            end
            if (pop) rp_reg <= rp_reg + QAW'(1);
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    // Hold destination bytes and queue entries
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= c;
            if (phase_reg == PH_DEST) dest_reg[pos_reg] <= in_byte;
        end
    end

endmodule

/* hw/rtl/ax25t_back.sv */
// ----------------------------------------------------------------------------
// ax25t_back: text emitter
// Expands each queued command into characters, one per cycle while the output is free.
// ----------------------------------------------------------------------------
module ax25t_back import ax25t_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    input  logic        insert_mode,
    input  logic        insert_enable,
    input  logic [47:0] own_call,
    input  logic [3:0]  own_ssid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        out_last,
    output logic        out_done
);

    est_t        st_reg, st_next;
    cmd_t        c_reg;
    logic [2:0]  idx_reg, idx_next;   // byte index in dest/own call
    logic [1:0]  dig_reg, dig_next;   // ssid sub-step: 0 '-', 1 tens, 2 units
    logic [7:0]  cnt_reg, cnt_next;
    logic        trunc_reg, trunc_next;
    logic [7:0]  prev_reg, prev_next;
    logic        ov_reg;
    logic [7:0]  oc_reg, oc_next;
    logic        ol_reg, od_reg, ol_next, od_next;
    logic        emit, can, take;
    logic [3:0]  sv;
    logic [7:0]  dch, och, ch;
    logic        skip;

    // Output register frees when consumed
    assign can       = !ov_reg || out_ready;
    assign cmd_ready = (st_reg == ST_IDLE) && can;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = ov_reg;
    assign out_char  = oc_reg;
    assign out_last  = ol_reg;
    assign out_done  = od_reg;

    // Select the ssid and call bytes for the current step
    always_comb begin
        dch = c_reg.dest[8*idx_reg +: 8];
        och = own_call[8*(3'd5 - idx_reg) +: 8];
        case (st_reg)
            ST_DSSID: sv = c_reg.dest[52:49];
            ST_OSSID: sv = own_ssid;
            default:  sv = c_reg.b[4:1];
        endcase
    end

    // Sequence one character per cycle while the output register is free
    always_comb begin
        st_next = st_reg; idx_next = idx_reg; dig_next = dig_reg;
        cnt_next = cnt_reg; trunc_next = trunc_reg; prev_next = prev_reg;
        emit = 1'b0; ch = 8'd0; od_next = 1'b0; skip = 1'b0;
        oc_next = oc_reg; ol_next = 1'b0;
        if (st_reg == ST_IDLE) begin
            if (take) begin
                idx_next = '0; dig_next = '0;
                case (cmd.phase)
                    3'(PH_SRC):  st_next = (cmd.pos == 3'd6) ? ST_SSID : ST_CALL;
                    3'(PH_DIGI): st_next = (cmd.pos == 3'd0) ? ST_COMMA :
                                           (cmd.pos == 3'd6) ? ST_SSID : ST_CALL;
                    3'(PH_INFO): st_next = trunc_reg ? ST_FIN : ST_INFO;
                    default:     st_next = ST_FIN;
                endcase
            end
        end else if (can) begin
            case (st_reg)
                ST_COMMA: begin emit = 1'b1; ch = 8'h2C; st_next = ST_CALL; end
                ST_CALL: begin
                    ch = {1'b0, c_reg.b[7:1]}; emit = (ch != 8'h20);
                    st_next = ST_FIN;
                end
                ST_SSID, ST_DSSID, ST_OSSID: begin
                    if (sv == 4'd0) skip = 1'b1;
                    else if (dig_reg == 2'd0) begin
                        emit = 1'b1; ch = 8'h2D; dig_next = (sv >= 4'd10) ? 2'd1 : 2'd2;
                    end else if (dig_reg == 2'd1) begin
                        emit = 1'b1; ch = 8'h31; dig_next = 2'd2;
                    end else begin
                        emit = 1'b1; skip = 1'b1;
                        ch = 8'h30 + 8'((sv >= 4'd10) ? sv - 4'd10 : sv);
                    end
                    if (skip) begin
                        dig_next = '0;
                        case (st_reg)
                            ST_DSSID: st_next = c_reg.hdr_end ? ST_HOWN : ST_FIN;
                            ST_OSSID: st_next = ST_OSTAR;
                            default: begin
                                if (c_reg.phase == 3'(PH_SRC)) st_next = ST_GT;
                                else if (c_reg.b[7]) st_next = ST_STAR;
                                else st_next = c_reg.hdr_end ? ST_HOWN : ST_FIN;
                            end
                        endcase
                    end
                end
                ST_STAR: begin
                    emit = 1'b1; ch = 8'h2A;
                    st_next = c_reg.hdr_end ? ST_HOWN : ST_FIN;
                end
                ST_GT: begin emit = 1'b1; ch = 8'h3E; st_next = ST_DCALL; end
                ST_DCALL: begin
                    ch = {1'b0, dch[7:1]}; emit = (ch != 8'h20);
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd5) begin idx_next = '0; st_next = ST_DSSID; end
                end
                ST_HOWN: begin
                    if (insert_mode && insert_enable) begin
                        emit = 1'b1; ch = 8'h2C; st_next = ST_OCALL; idx_next = '0;
                    end else st_next = ST_COLON;
                end
                ST_OCALL: begin
                    if (och == 8'd0) st_next = ST_OSSID;
                    else begin
                        emit = 1'b1; ch = och; idx_next = idx_reg + 3'd1;
                        if (idx_reg == 3'd5) st_next = ST_OSSID;
                    end
                end
                ST_OSTAR: begin emit = 1'b1; ch = 8'h2A; st_next = ST_COLON; end
                ST_COLON: begin emit = 1'b1; ch = 8'h3A; st_next = ST_FIN; end
                ST_INFO: begin
                    emit = 1'b1; ch = c_reg.b;
                    st_next = (cnt_reg == 8'd255 || cnt_reg + 8'd1 > 8'(MAX_LINE))
                              ? ST_TILDE : ST_FIN;
                end
                ST_TILDE: begin
                    emit = 1'b1; ch = 8'h7E; trunc_next = 1'b1; st_next = ST_FIN;
                end
                ST_CR: begin emit = 1'b1; ch = 8'h0D; st_next = ST_LF; end
                ST_LF: begin emit = 1'b1; ch = 8'h0A; st_next = ST_NUL; end
                ST_NUL: begin
                    emit = 1'b1; ch = 8'h00; od_next = 1'b1; ol_next = 1'b1;
                    st_next = ST_IDLE;
                    cnt_next = '0; trunc_next = 1'b0; prev_next = '0;
                end
                ST_FIN: begin
                    if (c_reg.fend) st_next = (prev_reg == 8'h0D) ? ST_LF : ST_CR;
                    else st_next = ST_IDLE;
                end
                default: st_next = ST_IDLE;
            endcase
            if (emit && st_reg != ST_NUL) begin
                prev_next = ch;
                if (cnt_reg != 8'd255) cnt_next = cnt_reg + 8'd1;
            end
            if (emit) oc_next = ch;
        end
    end

    // Find which destination steps still print something
    logic [5:0] dblank, dmore;
    logic       dquiet;
    always_comb begin
        for (int j = 0; j < 6; j++) dblank[j] = (c_reg.dest[8*j+1 +: 7] == 7'h20);
        dmore  = ~dblank & (6'h3E << idx_reg);
        dquiet = (c_reg.dest[52:49] == 4'd0) && !c_reg.hdr_end;
    end

    // Mark the last character of this byte when no more follow
    logic last_here;
    always_comb begin
        last_here = ol_next;
        if (emit && !c_reg.fend) begin
            if (st_next == ST_FIN) last_here = 1'b1;
            // comma before a dropped space
            if (st_reg == ST_COMMA && c_reg.b[7:1] == 7'h20) last_here = 1'b1;
            // destination rest is blank with no ssid and no header end
            if (st_reg == ST_GT && dquiet && dblank == 6'h3F) last_here = 1'b1;
            if (st_reg == ST_DCALL && dquiet && dmore == 6'd0) last_here = 1'b1;
        end
    end

    // Hold state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            cnt_reg   <= '0;
            trunc_reg <= 1'b0;
            prev_reg  <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            dig_reg   <= '0;
        end else begin
            if (st_reg == ST_IDLE || can) begin
                st_reg    <= st_next;
                cnt_reg   <= cnt_next;
                trunc_reg <= trunc_next;
                prev_reg  <= prev_next;
                idx_reg   <= idx_next;
                dig_reg   <= dig_next;
            end
            if (can) ov_reg <= emit && (st_reg != ST_IDLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) c_reg <= cmd;
        if (can && emit && st_reg != ST_IDLE) begin
            oc_reg <= oc_next;
            ol_reg <= last_here;
            od_reg <= od_next;
        end
    end

endmodule

/* hw/rtl/ax25_header_to_text_line.sv */
// ----------------------------------------------------------------------------
// ax25_header_to_text_line: AX.25 UI frame to monitor text line
// Top level: configuration registers, parser front, queue, text emitter.
// ----------------------------------------------------------------------------
// Feed frame bytes in order on s_; the line "SRC>DST,DIGI*,...:info\r\n" and
// a 0x00 terminator come out on m_, at most one character per cycle. The
// parser classifies a byte in the cycle it is accepted and queues it in a
// 4-entry command queue, so input bytes can transfer back to back until the
// queue is full. The emitter takes a command while idle, then steps once per
// character, once per step that prints nothing (a dropped space, a zero
// SSID, a header end without own call) and once in a closing step; output
// stalls hold it. tlast marks the final character of a byte's run, tuser
// marks the terminating zero.
module ax25_header_to_text_line import ax25t_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // text_char
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // line_done
);

    localparam logic [1:0] R_MODE = 2'd0, R_EN = 2'd1, R_CALL = 2'd2, R_SSID = 2'd3;

    logic        mode_reg, en_reg;
    logic [47:0] call_reg;
    logic [3:0]  ssid_reg;
    logic        cv, cr;
    cmd_t        cmd;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0; en_reg <= 1'b0; call_reg <= '0; ssid_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                R_MODE:  mode_reg <= cfg_data[0];
                R_EN:    en_reg   <= cfg_data[0];
                R_CALL:  call_reg <= cfg_data;
                R_SSID:  ssid_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    ax25t_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_end(s_tlast),
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd)
    );

    ax25t_back u_back (
        .aclk, .aresetn,
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd),
        .insert_mode(mode_reg), .insert_enable(en_reg),
        .own_call(call_reg), .own_ssid(ssid_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_char(m_tdata), .out_last(m_tlast), .out_done(m_tuser)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: AX.25 UI frame to monitor text line testbench
// Drives raw frame bytes into the block and checks every text character against
// a built-in model of the line formatter. The run steps through several
// own-callsign settings. A directed table covers byte extremes, digipeaters,
// line-end handling and a short frame. Random frames follow, mostly well formed
// with random content, plus short frames and one long info field.
// ----------------------------------------------------------------------------
module tb import ax25t_pkg::*;;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_CALL   = 2'd2;
    localparam logic [1:0] REG_SSID   = 2'd3;
    localparam int         NUM_BYTES  = 230;
    localparam int         DRAIN      = 300;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } text_char_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;   // text_char
    logic        m_tlast;   // run_last
    logic        m_tuser;   // line_done

    // Formatter state mirrored from the block
    logic        own_mode, own_en;
    logic [47:0] own_call;
    logic [3:0]  own_ssid;
    logic [7:0]  dest_bytes [7];
    int          field_pos, digi_cnt, char_cnt;
    phase_t      field;
    logic        cut_off;
    logic [7:0]  last_char;

    text_char_t  text_q[$];
    int          errors = 0, bytes_sent = 0, lines_seen = 0, chars_seen = 0;
    bit          stall_on = 0;

    // {frame_end, frame_byte}: addresses, digipeater with H bit, extremes, CR end
    localparam logic [8:0] DIRECTED [27] = '{
        9'h082, 9'h0A0, 9'h040, 9'h040, 9'h040, 9'h040, 9'h07E,
        9'h09C, 9'h060, 9'h040, 9'h040, 9'h040, 9'h040, 9'h014,
        9'h0AE, 9'h040, 9'h040, 9'h040, 9'h040, 9'h040, 9'h083,
        9'h003, 9'h0F0, 9'h0FF, 9'h000, 9'h10D,
        9'h100
    };

    ax25_header_to_text_line dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ---- prediction ----
    function automatic void put_char(logic [7:0] c, logic done = 0);
        text_q.push_back('{c, 1'b0, done});
        if (char_cnt < 255) char_cnt++;
        last_char = c;
    endfunction

    function automatic void put_call(logic [7:0] b);
        if ((b >> 1) != 8'h20) put_char(b >> 1);
    endfunction

    function automatic void put_ssid(logic [3:0] s);
        if (s == 0) return;
        put_char("-");
        if (s < 10) put_char(8'h30 + s);
        else begin
            put_char(8'h31);
            put_char(8'h30 + s - 10);
        end
    endfunction

    function automatic void close_header();
        logic [7:0] c;
        if (own_mode && own_en) begin
            put_char(",");
            for (int i = 0; i < 6; i++) begin
                c = own_call[47 - 8*i -: 8];
                if (c == 0) break;
                put_char(c);
            end
            put_ssid(own_ssid);
            put_char("*");
        end
        put_char(":");
        field = PH_CTRL;
        field_pos = 0;
    endfunction

    function automatic void clear_line();
        field_pos = 0;
        field = PH_DEST;
        digi_cnt = 0;
        char_cnt = 0;
        cut_off = 0;
        last_char = 0;
    endfunction

    function automatic void predict_text(logic [7:0] b, logic fend);
        int start;
        start = text_q.size();
        case (field)
            PH_DEST: begin
                dest_bytes[field_pos] = b;
                field_pos++;
                if (field_pos >= 7) begin
                    field_pos = 0;
                    field = PH_SRC;
                end
            end
            PH_SRC: begin
                if (field_pos < 6) begin
                    put_call(b);
                    field_pos++;
                end else begin
                    put_ssid(b[4:1]);
                    put_char(">");
                    for (int i = 0; i < 6; i++) put_call(dest_bytes[i]);
                    put_ssid(dest_bytes[6][4:1]);
                    field_pos = 0;
                    if (b[0]) close_header();
                    else field = PH_DIGI;
                end
            end
            PH_DIGI: begin
                if (field_pos == 0) put_char(",");
                if (field_pos < 6) begin
                    put_call(b);
                    field_pos++;
                end else begin
                    put_ssid(b[4:1]);
                    if (b[7]) put_char("*");
                    digi_cnt++;
                    field_pos = 0;
                    if (b[0] || digi_cnt >= MAX_DIGIS) close_header();
                end
            end
            PH_CTRL: field = PH_PID;
            PH_PID:  field = PH_INFO;
            default: begin
                if (!cut_off) begin
                    put_char(b);
                    if (char_cnt > MAX_LINE) begin
                        put_char("~");
                        cut_off = 1;
                    end
                end
            end
        endcase
        if (fend) begin
            if (last_char != 8'h0d) put_char(8'h0d);
            put_char(8'h0a);
            put_char(8'h00, 1);
            clear_line();
        end
        if (text_q.size() > start) text_q[$].last = 1;
    endfunction

    // ---- stimulus helpers ----
    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 0;
        case (idx)
            REG_MODE:   own_mode = val[0];
            REG_ENABLE: own_en = val[0];
            REG_CALL:   own_call = val;
            default:    own_ssid = val[3:0];
        endcase
    endtask

    task automatic set_station(logic m, logic e, logic [47:0] call, logic [3:0] ssid);
        // stop sending, then let queued bytes that produce no text finish first
        s_tvalid = 0;
        while (text_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        write_reg(REG_MODE, m);
        write_reg(REG_ENABLE, e);
        write_reg(REG_CALL, call);
        write_reg(REG_SSID, ssid);
    endtask

    int burst_left = 0;

    // Hold one byte on the bus until its transfer, with random gaps between bursts
    task automatic send_byte(logic [7:0] b, logic fend);
        if (burst_left == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid = 1;
        s_tdata = b;
        s_tlast = fend;
        do @(posedge aclk); while (!s_tready);
        predict_text(b, fend);
        bytes_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] call_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h40;
            1:       return 8'($urandom);
            default: return 8'($urandom_range(8'h41, 8'h5A)) << 1;
        endcase
    endfunction

    // Well-formed frame with random content, or a frame cut short
    task automatic send_frame(int info_len);
        int   total, n, digis;
        logic [7:0] f [$];
        digis = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++) f.push_back(call_byte());
        f.push_back(8'($urandom) & 8'hFE);
        for (int i = 0; i < 6; i++) f.push_back(call_byte());
        f.push_back((8'($urandom) & 8'hFE) | (digis == 0));
        for (int d = 0; d < digis; d++) begin
            for (int i = 0; i < 6; i++) f.push_back(call_byte());
            f.push_back((8'($urandom) & 8'hFE) | (d == digis - 1));
        end
        f.push_back(8'h03);
        f.push_back(8'hF0);
        for (int i = 0; i < info_len; i++)
            f.push_back($urandom_range(0, 3) == 0 ? 8'($urandom)
                                                  : 8'($urandom_range(8'h20, 8'h7E)));
        if (info_len > 0 && $urandom_range(0, 2) == 0) f[$] = 8'h0d;
        total = f.size();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
        for (int i = 0; i < n; i++) send_byte(f[i], i == n - 1);
    endtask

    // ---- receiver stall pattern: alternate free-running and random stretches ----
    int stall_span = 0;
    always @(negedge aclk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(5, 60);
            stall_on = $urandom_range(0, 2) != 0;
        end else stall_span--;
        m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // ---- checker ----
    always @(posedge aclk) begin
        text_char_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            chars_seen++;
            if (text_q.size() == 0) begin
                $error("unexpected char 0x%02h", m_tdata);
                errors++;
            end else begin
                exp = text_q.pop_front();
                if (m_tdata !== exp.ch) begin
                    $error("text_char exp 0x%02h got 0x%02h", exp.ch, m_tdata);
                    errors++;
                end
                if (m_tlast !== exp.last) begin
                    $error("run_last exp %0b got %0b", exp.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== exp.done) begin
                    $error("line_done exp %0b got %0b", exp.done, m_tuser);
                    errors++;
                end
                if (m_tuser === 1'b1) lines_seen++;
            end
        end
    end

    initial begin
        own_mode = 0; own_en = 0; own_call = '0; own_ssid = '0;
        clear_line();
        repeat (5) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed table at reset settings, then with own call inserted
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        set_station(1, 1, 48'h4E_30_43_41_4C_4C, 4'd15);
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // Random frames across station settings; one long info field forces truncation
        send_frame(195);
        while (bytes_sent < NUM_BYTES + 54) begin
            case ($urandom_range(0, 5))
                0: set_station(1, 0, 48'($urandom) << 16 | 48'($urandom), 4'($urandom));
                1: set_station(0, 1, 48'hFF_FF_FF_FF_FF_FF, 4'd9);
                2: set_station(1, 1, 48'h41_42_00_43_44_45, 4'd0);
                3: set_station(1, 1, {16'($urandom), 32'($urandom)}, 4'($urandom));
                default: ;
            endcase
            send_frame($urandom_range(0, 12));
        end
        s_tvalid = 0;

        fork
            begin
                while (text_q.size() != 0) @(negedge aclk);
                repeat (DRAIN) @(negedge aclk);
            end
            begin
                repeat (200000) @(negedge aclk);
                $error("drain timeout, %0d chars outstanding", text_q.size());
                errors++;
            end
        join_any
        disable fork;

        $display("Sent %0d frame bytes; checked %0d text chars over %0d lines.",
                 bytes_sent, chars_seen, lines_seen);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
